@@ sv/readout_hit_time_merger_unit_assert.svh @@
// Assertion macros for the hit time merger
`ifndef READOUT_HIT_TIME_MERGER_UNIT_ASSERT_SVH
`define READOUT_HIT_TIME_MERGER_UNIT_ASSERT_SVH
// implication checked every clock, quiet in reset
`define RHTM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// next-cycle implication
`define RHTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/rhtm_pkg.sv @@
// ---------------------------------------------------------------------------
// rhtm_pkg
// Shared types and constants of the hit time merger.
// ---------------------------------------------------------------------------
package rhtm_pkg;
    localparam int MaxHits = 64;
    localparam int IdxW = $clog2(MaxHits);
    localparam int CntW = $clog2(MaxHits + 1);

    localparam logic [1:0] RegDiv   = 2'd0;
    localparam logic [1:0] RegGap   = 2'd1;
    localparam logic [1:0] RegSlope = 2'd2;
    localparam logic [1:0] RegAdd   = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD, ST_DIV, ST_MUL, ST_RND, ST_WR,
        ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_SORT_KEY,
        ST_MRG_RD, ST_MRG_STEP, ST_EMIT
    } t_state;

    // one buffer entry, packed for the RAM
    typedef struct packed {
        logic [15:0]        rid;
        logic [31:0]        tim;
        logic [23:0]        tru;
        logic signed [31:0] cor;
        logic               chg;
    } t_entry;
    localparam int EntryW = $bits(t_entry);

    typedef struct packed {
        logic div_start;
        logic mul_start;
        logic rnd_start;
        logic wr_new;
        logic sort_rd;
        logic sort_wr;
        logic key_wr;
        logic mrg_first;
        logic mrg_acc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic less;
        logic split;
    } t_sts;
endpackage

@@ sv/rhtm_ram.sv @@
// ---------------------------------------------------------------------------
// rhtm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module rhtm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/rhtm_datapath.sv @@
// ---------------------------------------------------------------------------
// rhtm_datapath
// Hit conditioning, insertion sort over the buffer RAM and cluster merging.
// ---------------------------------------------------------------------------
module rhtm_datapath import rhtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [IdxW-1:0]    i_raddr,
    input  logic [IdxW-1:0]    i_waddr,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [15:0]        i_readout_id,
    input  logic signed [23:0] i_deposit,
    input  logic signed [15:0] i_z_position,
    input  logic               i_at_origin,
    input  logic [31:0]        i_hit_time,
    output logic [15:0]        o_cluster_readout,
    output logic [31:0]        o_cluster_time,
    output logic signed [31:0] o_corrected_energy,
    output logic [30:0]        o_true_energy,
    output logic               o_charged
);
    // configuration registers
    logic [3:0]         r_div;
    logic [31:0]        r_gap;
    logic signed [23:0] r_slope;
    logic [23:0]        r_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= 4'd2; r_gap <= 32'd320; r_slope <= '0; r_add <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegDiv:   r_div   <= i_cfg_data[3:0];
                RegGap:   r_gap   <= i_cfg_data;
                RegSlope: r_slope <= i_cfg_data[23:0];
                RegAdd:   r_add   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // captured hit
    logic [15:0]        r_rid;
    logic [31:0]        r_tim;
    logic signed [15:0] r_z;
    logic               r_org;
    logic               r_neg;
    logic [22:0]        r_rem;
    logic [23:0]        r_quo;
    logic [4:0]         r_bit;
    logic               r_div_busy;
    logic [23:0]        n_rem_sh;

    // restoring divider on the deposit magnitude, one bit a cycle
    logic [23:0] w_mag;
    logic [3:0]  w_dv;
    assign w_mag = i_deposit[23] ? 24'(-i_deposit) : i_deposit;
    assign w_dv  = (r_div == 4'd0) ? 4'd1 : r_div;
    logic [23:0] r_num;
    assign n_rem_sh = {r_rem, r_num[23]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_rid <= i_readout_id; r_tim <= i_hit_time; r_z <= i_z_position;
            r_org <= i_at_origin; r_neg <= i_deposit[23];
            r_num <= w_mag; r_rem <= '0; r_quo <= '0; r_bit <= 5'd24;
            r_div_busy <= 1'b1;
        end else if (r_div_busy) begin
            r_num <= {r_num[22:0], 1'b0};
            if (n_rem_sh >= {20'd0, w_dv}) begin
                r_rem <= 23'(n_rem_sh - {20'd0, w_dv});
                r_quo <= {r_quo[22:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh[22:0];
                r_quo <= {r_quo[22:0], 1'b0};
            end
            r_bit <= r_bit - 5'd1;
            if (r_bit == 5'd1) r_div_busy <= 1'b0;
        end
    end

    // share: a positive quotient of a nonnegative deposit; others are not positive
    logic               w_pos;
    logic               w_zero;
    assign w_zero = (r_quo == '0);
    assign w_pos  = !r_neg && !w_zero;

    // factor then product, each registered
    logic signed [40:0] r_factor;
    logic signed [64:0] r_prod;
    logic signed [31:0] w_corr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start)
            r_factor <= 41'sd16777216 + 41'(r_z) * 41'(r_slope);
        if (i_cmd.rnd_start)
            r_prod <= $signed({1'b0, r_quo}) * r_factor;
    end
    logic signed [64:0] w_rnd;
    assign w_rnd = (r_prod + 65'sd8388608) >>> 24;
    always_comb begin
        if (w_rnd > 65'sd2147483647) w_corr = 32'h7fffffff;
        else if (w_rnd < -65'sd2147483648) w_corr = 32'h80000000;
        else w_corr = w_rnd[31:0];
    end

    // a negative share, or a zero share at the origin, is charged
    t_entry w_new;
    always_comb begin
        w_new.rid = r_rid;
        w_new.tim = r_tim;
        w_new.tru = w_pos ? r_quo : 24'd0;
        w_new.cor = w_pos ? w_corr : 32'sd0;
        w_new.chg = (r_neg && !w_zero) || (w_zero && r_org);
    end

    // buffer RAM
    t_entry w_rd, r_key, w_wd;
    logic   w_we;
    logic   w_less;
    logic   w_split;
    assign w_we = i_cmd.wr_new || i_cmd.sort_wr || i_cmd.key_wr;
    assign w_wd = i_cmd.wr_new ? w_new : ((i_cmd.sort_wr && w_less) ? w_rd : r_key);
    rhtm_ram #(.Width(EntryW), .Depth(MaxHits)) u_buf (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_waddr), .i_wdata(w_wd),
        .i_raddr(i_raddr), .o_rdata(w_rd)
    );

    // sort key holds the entry being inserted
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_rd) r_key <= w_rd;
    end
    assign w_less = (r_key.rid != w_rd.rid) ? (r_key.rid < w_rd.rid)
                                            : (r_key.tim < w_rd.tim);

    // cluster accumulation
    logic [15:0]        r_crid;
    logic [31:0]        r_ctim, r_ptim;
    logic signed [38:0] r_cs;
    logic [30:0]        r_ts;
    logic               r_cch;
    logic [31:0]        w_step;
    assign w_step = w_rd.tim - r_ptim;
    assign w_split = (w_rd.rid != r_crid) || (w_step > r_gap);

    assign o_sts = {!r_div_busy, w_less, w_split};

    logic [31:0] w_tsum;
    assign w_tsum = {1'b0, r_ts} + {8'd0, w_rd.tru};
    always_ff @(posedge i_clk) begin
        if (i_cmd.mrg_first) begin
            r_crid <= w_rd.rid; r_ctim <= w_rd.tim; r_ptim <= w_rd.tim;
            r_cs <= 39'(w_rd.cor); r_ts <= {7'd0, w_rd.tru}; r_cch <= w_rd.chg;
        end else if (i_cmd.mrg_acc) begin
            r_ptim <= w_rd.tim;
            r_cs <= r_cs + 39'(w_rd.cor);
            r_ts <= w_tsum[31] ? 31'h7fffffff : w_tsum[30:0];
            r_cch <= r_cch | w_rd.chg;
        end
    end

    // output register
    logic signed [39:0] w_cout;
    assign w_cout = 40'(r_cs) + (r_cch ? $signed({16'd0, r_add}) : 40'sd0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_cluster_readout <= r_crid;
            o_cluster_time <= r_ctim;
            o_true_energy <= r_ts;
            o_charged <= r_cch;
            if (w_cout > 40'sd2147483647) o_corrected_energy <= 32'h7fffffff;
            else if (w_cout < -40'sd2147483648) o_corrected_energy <= 32'h80000000;
            else o_corrected_energy <= w_cout[31:0];
        end
    end
endmodule

@@ sv/rhtm_ctrl.sv @@
// ---------------------------------------------------------------------------
// rhtm_ctrl
// Sequencer: load, insertion sort, merge pass and cluster emission.
// ---------------------------------------------------------------------------
module rhtm_ctrl import rhtm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_last_hit,
    output logic            o_busy,
    output t_cmd            o_cmd,
    input  t_sts            i_sts,
    output logic [IdxW-1:0] o_raddr,
    output logic [IdxW-1:0] o_waddr,
    output logic            o_valid,
    output logic            o_overflow,
    output logic            o_last_cluster
);
    t_state r_state, n_state;
    logic [CntW-1:0] r_fill, n_fill;
    logic            r_drop, n_drop, r_last, n_last;
    logic [CntW-1:0] r_i, n_i, r_j, n_j;
    logic            r_valid, n_valid, r_lc, n_lc, r_ovf, n_ovf;
    logic            r_lcl, n_lcl;
    logic            w_accept;

    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_fill <= '0; r_drop <= 1'b0; r_last <= 1'b0;
            r_i <= '0; r_j <= '0; r_valid <= 1'b0; r_lc <= 1'b0; r_ovf <= 1'b0;
            r_lcl <= 1'b0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_drop <= n_drop;
            r_last <= n_last; r_i <= n_i; r_j <= n_j;
            r_valid <= n_valid; r_lc <= n_lc; r_ovf <= n_ovf;
            r_lcl <= n_lcl;
        end
    end

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_drop = r_drop; n_last = r_last;
        n_i = r_i; n_j = r_j; n_valid = 1'b0; n_lc = r_lc; n_ovf = r_ovf;
        n_lcl = 1'b0;
        o_cmd = '0;
        o_busy = (r_state != ST_LOAD);
        o_raddr = r_j[IdxW-1:0];
        o_waddr = r_fill[IdxW-1:0];
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    n_last = i_last_hit;
                    if (r_fill < CntW'(MaxHits)) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_drop = 1'b1;
                        if (i_last_hit) begin
                            n_i = CntW'(1);
                            n_state = ST_SORT_RD;
                        end
                    end
                end
            end
            ST_DIV: if (i_sts.div_done) begin
                o_cmd.mul_start = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.rnd_start = 1'b1;
                n_state = ST_RND;
            end
            ST_RND: n_state = ST_WR;
            ST_WR: begin
                o_cmd.wr_new = 1'b1;
                n_fill = r_fill + CntW'(1);
                if (r_last) begin
                    n_i = CntW'(1);
                    n_state = ST_SORT_RD;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            // read key at r_i; then walk r_j down comparing entry r_j-1
            ST_SORT_RD: begin
                if (r_i >= r_fill) begin
                    n_j = '0;
                    n_state = ST_MRG_RD;
                end else begin
                    o_raddr = r_i[IdxW-1:0];
                    n_j = r_i;
                    n_state = ST_SORT_WR;
                end
            end
            ST_SORT_WR: begin
                // key captured this cycle; request the predecessor
                o_cmd.sort_rd = 1'b1;
                o_raddr = IdxW'(r_j - CntW'(1));
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                o_cmd.sort_wr = 1'b1;
                o_waddr = r_j[IdxW-1:0];
                if (i_sts.less) begin
                    // shifted predecessor up; key goes lower
                    n_j = r_j - CntW'(1);
                    if (r_j == CntW'(1)) begin
                        n_state = ST_SORT_KEY;
                    end else begin
                        o_raddr = IdxW'(r_j - CntW'(2));
                    end
                end else begin
                    n_i = r_i + CntW'(1);
                    n_state = ST_SORT_RD;
                end
            end
            // key lands at entry 0
            ST_SORT_KEY: begin
                o_cmd.key_wr = 1'b1;
                o_waddr = '0;
                n_i = r_i + CntW'(1);
                n_state = ST_SORT_RD;
            end
            ST_MRG_RD: begin
                if (r_fill == '0) begin
                    n_fill = '0; n_drop = 1'b0; n_state = ST_LOAD;
                end else begin
                    o_raddr = '0;
                    n_j = CntW'(1);
                    n_state = ST_MRG_STEP;
                end
            end
            // r_lc marks that the current cluster has its first hit
            ST_MRG_STEP: begin
                o_raddr = r_j[IdxW-1:0];
                if (!r_lc) begin
                    o_cmd.mrg_first = 1'b1;
                    n_lc = 1'b1;
                    n_j = r_j + CntW'(1);
                end else if (r_j - CntW'(1) >= r_fill) begin
                    o_cmd.emit = 1'b1; n_valid = 1'b1; n_ovf = r_drop;
                    n_lcl = 1'b1;
                    n_state = ST_EMIT;
                end else if (i_sts.split) begin
                    o_cmd.emit = 1'b1; n_valid = 1'b1; n_ovf = r_drop;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.mrg_acc = 1'b1;
                    n_j = r_j + CntW'(1);
                end
            end
            ST_EMIT: begin
                if (r_j - CntW'(1) >= r_fill) begin
                    n_fill = '0; n_drop = 1'b0; n_lc = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    o_raddr = IdxW'(r_j - CntW'(1));
                    n_state = ST_MRG_STEP;
                    n_lc = 1'b0;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end
    assign o_valid = r_valid;
    assign o_overflow = r_ovf;
    assign o_last_cluster = r_lcl;
endmodule

@@ sv/readout_hit_time_merger_unit.sv @@
// ---------------------------------------------------------------------------
// readout_hit_time_merger_unit
// Event hit buffer with energy conditioning, readout/time sort and merging.
// ---------------------------------------------------------------------------
// A hit is taken when start is high and busy low. Each stored hit holds busy
// through the divider, then factor, product and buffer write, so no new hit
// is taken before the last one is stored; a hit that finds the buffer full is
// dropped at once without going busy, unless it is the last hit, which starts
// the sort. After the last hit, an insertion sort runs over the buffer RAM,
// quadratic in hits, and then the merge pass. Each cluster shows for one
// cycle on o_valid, never on back-to-back cycles; the receiver cannot stall,
// so results must be taken as they come.
module readout_hit_time_merger_unit import rhtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_readout_id,
    input  logic signed [23:0] i_deposit,
    input  logic signed [15:0] i_z_position,
    input  logic               i_at_origin,
    input  logic [31:0]        i_hit_time,
    input  logic               i_last_hit,
    output logic               o_valid,
    output logic [15:0]        o_cluster_readout,
    output logic [31:0]        o_cluster_time,
    output logic signed [31:0] o_corrected_energy,
    output logic [30:0]        o_true_energy,
    output logic               o_charged,
    output logic               o_overflow,
    output logic               o_last_cluster
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic [IdxW-1:0] w_raddr, w_waddr;

    rhtm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_last_hit, .o_busy(busy),
        .o_cmd(w_cmd), .i_sts(w_sts), .o_raddr(w_raddr), .o_waddr(w_waddr),
        .o_valid, .o_overflow, .o_last_cluster
    );
    rhtm_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts), .i_raddr(w_raddr),
        .i_waddr(w_waddr), .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_readout_id,
        .i_deposit, .i_z_position, .i_at_origin, .i_hit_time,
        .o_cluster_readout, .o_cluster_time, .o_corrected_energy,
        .o_true_energy, .o_charged
    );
endmodule

@@ sv/rhtm_checker.sv @@
// ---------------------------------------------------------------------------
// rhtm_checker
// Port-level checks of the hit time merger.
// ---------------------------------------------------------------------------
`include "readout_hit_time_merger_unit_assert.svh"
module rhtm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last_cluster
);
    // a last cluster is always a valid beat
    `RHTM_ASSERT_IMPL(a_last_valid, o_last_cluster, o_valid)
    // results only appear while the block is working or just finishing
    `RHTM_ASSERT_IMPL(a_valid_busy, o_valid && !o_last_cluster, busy)
    // each result strobe lasts a single cycle
    `RHTM_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid)
endmodule

bind readout_hit_time_merger_unit rhtm_checker u_rhtm_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_last_cluster
);

@@ tb/tb_readout_hit_time_merger_unit.sv @@
// ---------------------------------------------------------------------------
// tb_readout_hit_time_merger_unit
// Self-checking bench for the hit time merger. Hits are sent one beat at a
// time on the start/busy handshake. A local model conditions each hit, then
// sorts and merges the buffered event on the last hit, and queues the
// clusters it expects. A monitor checks each cluster strobe against the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_readout_hit_time_merger_unit;
    import rhtm_pkg::*;

    localparam int CycleLimit = 600000;

    typedef struct {
        logic [15:0]        rid;
        logic signed [23:0] dep;
        logic signed [15:0] z;
        logic               org;
        logic [31:0]        tim;
        logic               last;
    } t_hit;

    typedef struct {
        logic [15:0] rid;
        logic [31:0] tim;
        longint      tru;
        longint      cor;
        logic        chg;
    } t_held;

    typedef struct packed {
        logic [15:0] rid;
        logic [31:0] tim;
        logic [31:0] cor;
        logic [30:0] tru;
        logic        chg;
        logic        ovf;
        logic        last;
    } t_cluster;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = RegDiv;
    logic [31:0]        i_cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        i_readout_id = '0;
    logic signed [23:0] i_deposit = '0;
    logic signed [15:0] i_z_position = '0;
    logic               i_at_origin = 1'b0;
    logic [31:0]        i_hit_time = '0;
    logic               i_last_hit = 1'b0;
    logic               o_valid;
    logic [15:0]        o_cluster_readout;
    logic [31:0]        o_cluster_time;
    logic signed [31:0] o_corrected_energy;
    logic [30:0]        o_true_energy;
    logic               o_charged;
    logic               o_overflow;
    logic               o_last_cluster;

    // model copy of the registers and the event buffer
    longint    divisor_cfg;
    longint    gap_cfg;
    longint    slope_cfg;
    longint    charge_add_cfg;
    t_held     event_hits[$];
    logic      hits_dropped;
    t_cluster  pending_clusters[$];

    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;

    readout_hit_time_merger_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .start, .busy,
        .i_readout_id, .i_deposit, .i_z_position, .i_at_origin, .i_hit_time,
        .i_last_hit, .o_valid, .o_cluster_readout, .o_cluster_time,
        .o_corrected_energy, .o_true_energy, .o_charged, .o_overflow,
        .o_last_cluster
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // cluster checker
    always @(posedge i_clk) begin
        t_cluster got;
        t_cluster want;
        if (i_rst_n && o_valid) begin
            got = {o_cluster_readout, o_cluster_time, o_corrected_energy,
                   o_true_energy, o_charged, o_overflow, o_last_cluster};
            if (pending_clusters.size() == 0) begin
                errors++;
                $display("%0t unexpected cluster: actual rid=%h t=%h", $time,
                         got.rid, got.tim);
            end else begin
                want = pending_clusters.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t cluster mismatch: expected rid=%h t=%h ce=%h te=%h c=%b o=%b l=%b",
                             $time, want.rid, want.tim, want.cor, want.tru, want.chg,
                             want.ovf, want.last);
                    $display("%0t                   actual   rid=%h t=%h ce=%h te=%h c=%b o=%b l=%b",
                             $time, got.rid, got.tim, got.cor, got.tru, got.chg,
                             got.ovf, got.last);
                end
            end
        end
    end

    function automatic void queue_cluster(t_held c, logic fin);
        t_cluster r;
        longint   cs;
        longint   ts;
        cs = c.cor + (c.chg ? charge_add_cfg : 0);
        if (cs > 64'sd2147483647) cs = 64'sd2147483647;
        if (cs < -64'sd2147483648) cs = -64'sd2147483648;
        ts = (c.tru > 64'sd2147483647) ? 64'sd2147483647 : c.tru;
        r.rid = c.rid;
        r.tim = c.tim;
        r.cor = cs[31:0];
        r.tru = ts[30:0];
        r.chg = c.chg;
        r.ovf = hits_dropped;
        r.last = fin;
        pending_clusters = {pending_clusters, r};
    endfunction

    // condition one hit into the buffer; on the last hit sort and merge
    function automatic void predict_hit(t_hit h);
        longint share;
        longint corr;
        longint factor;
        t_held  e;
        t_held  cur;
        int     j;
        if (event_hits.size() < MaxHits) begin
            share = longint'(h.dep) / ((divisor_cfg == 0) ? 1 : divisor_cfg);
            corr = 0;
            e.chg = 1'b0;
            if (share > 0) begin
                factor = (64'sd1 <<< 24) + longint'(h.z) * slope_cfg;
                corr = (share * factor + (64'sd1 <<< 23)) >>> 24;
                if (corr > 64'sd2147483647) corr = 64'sd2147483647;
                if (corr < -64'sd2147483648) corr = -64'sd2147483648;
            end else if (share == 0) begin
                e.chg = h.org;
            end else begin
                e.chg = 1'b1;
                share = 0;
            end
            e.rid = h.rid;
            e.tim = h.tim;
            e.tru = share;
            e.cor = corr;
            event_hits = {event_hits, e};
        end else begin
            hits_dropped = 1'b1;
        end
        if (!h.last) return;

        // stable insertion sort by readout, then time
        for (int i = 1; i < event_hits.size(); i++) begin
            e = event_hits[i];
            j = i;
            while (j > 0 && (e.rid < event_hits[j-1].rid ||
                   (e.rid == event_hits[j-1].rid && e.tim < event_hits[j-1].tim))) begin
                event_hits[j] = event_hits[j-1];
                j--;
            end
            event_hits[j] = e;
        end

        if (event_hits.size() > 0) begin
            cur = event_hits[0];
            for (int i = 1; i < event_hits.size(); i++) begin
                if (event_hits[i].rid != event_hits[i-1].rid ||
                    longint'(event_hits[i].tim - event_hits[i-1].tim) > gap_cfg) begin
                    queue_cluster(cur, 1'b0);
                    cur = event_hits[i];
                end else begin
                    cur.cor += event_hits[i].cor;
                    cur.tru += event_hits[i].tru;
                    cur.chg |= event_hits[i].chg;
                end
            end
            queue_cluster(cur, 1'b1);
        end
        event_hits.delete();
        hits_dropped = 1'b0;
    endfunction

    // one hit beat; called and left at a falling edge
    task automatic send_hit(t_hit h);
        start = 1'b1;
        i_readout_id = h.rid;
        i_deposit = h.dep;
        i_z_position = h.z;
        i_at_origin = h.org;
        i_hit_time = h.tim;
        i_last_hit = h.last;
        while (busy) @(negedge i_clk);
        predict_hit(h);
        @(negedge i_clk);
        start = 1'b0;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
    endtask

    task automatic hit(logic [15:0] rid, logic signed [23:0] dep, logic signed [15:0] z,
                       logic org, logic [31:0] tim, logic last);
        t_hit h;
        h = '{rid, dep, z, org, tim, last};
        send_hit(h);
    endtask

    // register write once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        while (busy || pending_clusters.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            RegDiv:   divisor_cfg = data[3:0];
            RegGap:   gap_cfg = data;
            RegSlope: slope_cfg = longint'($signed(data[23:0]));
            RegAdd:   charge_add_cfg = data[23:0];
            default: ;
        endcase
    endtask

    // energy conditioning corners and the charged cases
    task automatic test_energy_corners();
        write_reg(RegDiv, 32'd1);
        write_reg(RegSlope, 32'h7F_FFFF);
        write_reg(RegAdd, 32'hFF_FFFF);
        write_reg(RegGap, 32'd0);
        hit(16'hFFFF, 24'sh7FFFFF, 16'sh7FFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        hit(16'hFFFF, 24'sh7FFFFF, 16'sh7FFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        hit(16'h0000, 24'sh800000, 16'sh8000, 1'b1, 32'h0, 1'b0);
        hit(16'h0001, 24'sh000000, 16'sh0000, 1'b1, 32'd5, 1'b0);
        hit(16'h0002, 24'sh000000, 16'sh1234, 1'b0, 32'd5, 1'b1);
        write_reg(RegSlope, 32'h80_0000);
        write_reg(RegDiv, 32'd0);
        hit(16'h0003, 24'sh7FFFFF, 16'sh7FFF, 1'b0, 32'd10, 1'b0);
        hit(16'h0003, 24'sh000001, 16'sh8000, 1'b0, 32'd10, 1'b0);
        hit(16'h0004, 24'sh000003, 16'sh0001, 1'b0, 32'd7, 1'b1);
        write_reg(RegDiv, 32'd15);
        write_reg(RegSlope, 32'h00_1000);
        hit(16'h0005, 24'sh00000E, 16'sh0100, 1'b1, 32'd3, 1'b0);
        hit(16'h0005, -24'sd14, 16'sh0100, 1'b0, 32'd3, 1'b0);
        hit(16'h0005, 24'sh123456, -16'sd300, 1'b0, 32'd4, 1'b1);
    endtask

    // merging at the gap edges and equal times
    task automatic test_merge_corners();
        write_reg(RegDiv, 32'd8);
        write_reg(RegGap, 32'd320);
        write_reg(RegAdd, 32'd0);
        hit(16'h0010, 24'sd8000, 16'sd0, 1'b0, 32'd1000, 1'b0);
        hit(16'h0010, 24'sd8000, 16'sd0, 1'b0, 32'd1320, 1'b0);
        hit(16'h0010, 24'sd8000, 16'sd0, 1'b0, 32'd1641, 1'b0);
        hit(16'h0010, 24'sd800, 16'sd0, 1'b0, 32'd1641, 1'b0);
        hit(16'h000F, 24'sd80, 16'sd0, 1'b0, 32'd1000, 1'b1);
        write_reg(RegGap, 32'hFFFF_FFFF);
        hit(16'h0020, 24'sd64, 16'sd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        hit(16'h0020, 24'sd64, 16'sd0, 1'b0, 32'h0000_0000, 1'b1);
    endtask

    // more hits than the buffer holds
    task automatic test_buffer_overflow();
        write_reg(RegGap, 32'd100);
        for (int i = 0; i < MaxHits + 2; i++)
            hit(16'($urandom_range(0, 3)), 24'($urandom_range(0, 4000)),
                16'($urandom), 1'($urandom), 32'($urandom_range(0, 3000)),
                i == MaxHits + 1);
    endtask

    // random events of a few hits each
    task automatic test_random_events(int n_hits);
        int    sent;
        int    len;
        t_hit  h;
        logic [31:0] t;
        sent = 0;
        while (sent < n_hits) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            if (len > n_hits - sent) len = n_hits - sent;
            t = $urandom;
            for (int i = 0; i < len; i++) begin
                h.rid = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
                case ($urandom_range(3))
                    0: h.dep = 24'($urandom);
                    1: h.dep = -24'($urandom_range(0, 50));
                    2: h.dep = 24'($urandom_range(0, 3));
                    default: h.dep = 24'($urandom_range(0, 200000));
                endcase
                h.z = 16'($urandom);
                h.org = 1'($urandom);
                t = t + (($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 700));
                h.tim = ($urandom_range(5) == 0) ? 32'($urandom) : t;
                h.last = (i == len - 1);
                send_hit(h);
                sent++;
            end
        end
    endtask

    initial begin
        divisor_cfg = 2;
        gap_cfg = 320;
        slope_cfg = 0;
        charge_add_cfg = 0;
        hits_dropped = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_energy_corners();
        test_merge_corners();
        test_buffer_overflow();

        send_idle_pct = 11;
        write_reg(RegDiv, 32'd2);
        write_reg(RegSlope, 32'h00_0400);
        write_reg(RegAdd, 32'd5000);
        write_reg(RegGap, 32'd320);
        test_random_events(12);
        send_idle_pct = 45;
        write_reg(RegDiv, 32'd3);
        write_reg(RegSlope, 32'hFF_F000);
        write_reg(RegGap, 32'd0);
        test_random_events(12);
        send_idle_pct = 0;
        write_reg(RegDiv, 32'd1);
        write_reg(RegGap, 32'd600);
        write_reg(RegAdd, 32'hFF_FFFF);
        test_random_events(12);

        while (pending_clusters.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+sv
sv/rhtm_pkg.sv
sv/rhtm_ram.sv
sv/rhtm_datapath.sv
sv/rhtm_ctrl.sv
sv/readout_hit_time_merger_unit.sv
sv/rhtm_checker.sv
tb/tb_readout_hit_time_merger_unit.sv
